@@ rtl/tqs_pkg.sv @@
// ----------------------------------------------------------------------------
// tqs_pkg
// Shared codes, field widths and sequencer states of the timer queue
// scheduler.
// ----------------------------------------------------------------------------
package tqs_pkg;

  // fixed field widths of the transactions
  localparam int TIME_W = 48;
  localparam int ID_W   = 4;
  localparam int WAIT_W = 32;

  // fire results buffered by one tick
  localparam int MAX_RESULTS = 16;

  localparam logic [TIME_W-1:0] NEVER_TIME = {TIME_W{1'b1}};
  localparam logic [TIME_W-1:0] LAST_TIME  = NEVER_TIME - 1'b1;
  localparam logic [WAIT_W-1:0] WAIT_NEVER = {WAIT_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_ARM    = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_ARM    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_FIRE   = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_t;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ARM_EXP,
    ST_ARM_DEC,
    ST_PU_RD,
    ST_PU_CMP,
    ST_TK_RD0,
    ST_TK_CHK,
    ST_TK_LAST,
    ST_SD_RDL,
    ST_SD_RDR,
    ST_SD_CMPR,
    ST_SD_MOVE,
    ST_TK_LIVE,
    ST_TK_DONE,
    ST_EM_RD,
    ST_EM_OUT
  } state_t;

  // result waiting to go out once the output register is free
  localparam state_t ST_RES = ST_TK_DONE;

endpackage

@@ rtl/tqs_if.sv @@
// ----------------------------------------------------------------------------
// tqs_cmd_if / tqs_rsp_if
// Valid/ready channels for command and result transactions.
// ----------------------------------------------------------------------------
interface tqs_cmd_if;
  import tqs_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [ID_W-1:0]   timer_id;
  logic [TIME_W-1:0] now_time;
  logic [WAIT_W-1:0] wait_time;
  logic              only_if_sooner;

  modport source (output valid, action, timer_id, now_time, wait_time, only_if_sooner,
                  input ready);
  modport sink (input valid, action, timer_id, now_time, wait_time, only_if_sooner,
                output ready);
endinterface

interface tqs_rsp_if;
  import tqs_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic              status;
  logic [ID_W-1:0]   fired_timer;
  logic [TIME_W-1:0] expiry;
  logic              new_earliest;
  logic [TIME_W-1:0] next_expiry;
  logic              last;

  modport source (output valid, kind, status, fired_timer, expiry, new_earliest,
                  next_expiry, last, input ready);
  modport sink (input valid, kind, status, fired_timer, expiry, new_earliest,
                next_expiry, last, output ready);
endinterface

@@ rtl/tqs_ram.sv @@
// ----------------------------------------------------------------------------
// tqs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/timer_queue_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// timer_queue_scheduler_top
// Timer slots with a min-heap of pending expirations and lazy cancel.
// ----------------------------------------------------------------------------
// Commands arrive on cmd (arm, cancel, tick) and results leave on rsp, both
// valid/ready; a transaction moves when valid and ready are high together.
// cmd.ready is high only while the sequencer is idle: one command is worked
// on at a time, through one shared time comparator and one heap RAM with one write and one read port.
// A cancel or an unused action goes straight to the result state; an arm
// first forms its expiry, then decides, and a push then rises through the
// heap one level per parent read and compare; the next command is taken
// in the cycle after the result is loaded. A tick reads and checks the
// heap top for each entry inspected and, for each pop, sifts down level by
// level; its fire results are buffered and then sent one after another,
// all carrying the heap top after the whole tick, the final one with last.
// A result sits in an output register, so a stalled receiver only holds the
// block once the next result is ready to go. Reset clears slot expiries to
// never, generations to zero and the heap count; heap contents need no
// clearing and the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
module timer_queue_scheduler_top
  import tqs_pkg::*;
#(
  parameter int NUM_TIMERS = 16,
  parameter int HEAP_DEPTH = 32,
  parameter int GEN_BITS   = 16
) (
  input logic      clk,
  input logic      rst,
  tqs_cmd_if.sink  cmd,
  tqs_rsp_if.source rsp
);

  localparam int IDW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int AW    = $clog2(HEAP_DEPTH);
  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int CW2   = AW + 2;
  localparam int EW    = TIME_W + IDW + GEN_BITS;
  localparam int FW    = $clog2(MAX_RESULTS);
  localparam int NW    = FW + 1;
  localparam int BW    = TIME_W + IDW;

  state_t state, state_next;

  // captured command
  logic [ID_W-1:0]   r_id;
  logic [TIME_W-1:0] r_now;
  logic [WAIT_W-1:0] r_wait;
  logic              r_soon;

  // slot tables
  logic [TIME_W-1:0]   slot_exp [NUM_TIMERS];
  logic [GEN_BITS-1:0] slot_gen [NUM_TIMERS];

  // heap control
  logic [CNT_W-1:0]    heap_count;
  logic [AW-1:0]       hp_i;
  logic [AW-1:0]       m_ix;
  logic                m_self;
  logic [TIME_W-1:0]   top_t;
  logic [TIME_W-1:0]   exp_r;
  logic [TIME_W-1:0]   e_t, best_t, pop_t;
  logic [IDW-1:0]      e_s, best_s, pop_s;
  logic [GEN_BITS-1:0] e_g, best_g, pop_g;

  // pending single result
  logic [1:0]        res_kind;
  logic              res_status;
  logic [ID_W-1:0]   res_id;
  logic [TIME_W-1:0] res_exp;
  logic              res_early;

  // fire buffer bookkeeping
  logic [NW-1:0] fire_n;
  logic [FW-1:0] em_ix;

  // heap ram ports
  logic          hp_we;
  logic [AW-1:0] hp_waddr, hp_raddr;
  logic [EW-1:0] hp_wdata, hp_rdata;
  logic [TIME_W-1:0]   rd_t;
  logic [IDW-1:0]      rd_s;
  logic [GEN_BITS-1:0] rd_g;

  // fire buffer ram ports
  logic          fb_we;
  logic [BW-1:0] fb_rdata;

  // shared comparator
  logic [TIME_W-1:0] cmp_a, cmp_b;
  logic              cmp_lt;

  logic              cmd_take, out_free, id_ok, cmd_id_ok, live, em_last;
  logic [IDW-1:0]    id_ix, cmd_ix;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] exp_calc;
  logic              soon_block, need_push, heap_full;
  logic [CW2-1:0]    l_w, r_w, cnt_w;
  logic              l_in, r_in;
  logic [AW-1:0]     parent;

  assign rd_t = hp_rdata[EW-1 -: TIME_W];
  assign rd_s = hp_rdata[GEN_BITS +: IDW];
  assign rd_g = hp_rdata[GEN_BITS-1:0];

  assign cmd_take  = cmd.valid && cmd.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign id_ok     = 32'(r_id) < NUM_TIMERS;
  assign cmd_id_ok = 32'(cmd.timer_id) < NUM_TIMERS;
  assign id_ix     = IDW'(r_id);
  assign cmd_ix    = IDW'(cmd.timer_id);

  // saturating expiry sum
  assign sum      = {1'b0, r_now} + (TIME_W + 1)'(r_wait);
  assign exp_calc = (r_wait == WAIT_NEVER) ? NEVER_TIME :
                    (sum >= {1'b0, LAST_TIME}) ? LAST_TIME : sum[TIME_W-1:0];

  // arm decision terms
  assign soon_block = r_soon && !cmp_lt;
  assign need_push  = exp_r != NEVER_TIME;
  assign heap_full  = need_push && (heap_count >= CNT_W'(HEAP_DEPTH));

  // heap index arithmetic
  assign l_w    = CW2'({hp_i, 1'b1});
  assign r_w    = l_w + 1'b1;
  assign cnt_w  = CW2'(heap_count);
  assign l_in   = l_w < cnt_w;
  assign r_in   = r_w < cnt_w;
  assign parent = (hp_i - 1'b1) >> 1;

  assign live    = pop_g == slot_gen[pop_s];
  assign em_last = (NW'(em_ix) + 1'b1) == fire_n;

  // shared comparator input select
  always_comb begin
    cmp_a = e_t;
    cmp_b = rd_t;
    case (state)
      ST_ARM_DEC: begin
        cmp_a = exp_r;
        cmp_b = slot_exp[id_ix];
      end
      ST_TK_CHK: begin
        cmp_a = r_now;
        cmp_b = rd_t;
      end
      ST_SD_RDR: begin
        cmp_a = rd_t;
        cmp_b = e_t;
      end
      ST_SD_CMPR: begin
        cmp_a = rd_t;
        cmp_b = best_t;
      end
      default: begin
        cmp_a = e_t;
        cmp_b = rd_t;
      end
    endcase
  end
  assign cmp_lt = cmp_a < cmp_b;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_take) begin
          if (cmd.action == ACT_ARM && cmd_id_ok) begin
            state_next = ST_ARM_EXP;
          end else if (cmd.action == ACT_TICK) begin
            state_next = ST_TK_RD0;
          end else begin
            state_next = ST_RES;
          end
        end
      end
      ST_ARM_EXP: state_next = ST_ARM_DEC;
      ST_ARM_DEC: begin
        if (soon_block || heap_full || !need_push) begin
          state_next = ST_RES;
        end else begin
          state_next = ST_PU_RD;
        end
      end
      ST_PU_RD: state_next = (hp_i == '0) ? ST_RES : ST_PU_CMP;
      ST_PU_CMP: state_next = cmp_lt ? ST_PU_RD : ST_RES;
      ST_TK_RD0: begin
        if (heap_count == '0 || fire_n == NW'(MAX_RESULTS)) begin
          state_next = ST_EM_RD;
        end else begin
          state_next = ST_TK_CHK;
        end
      end
      ST_TK_CHK: begin
        if (cmp_lt) begin
          state_next = ST_EM_RD;
        end else if (heap_count == CNT_W'(1)) begin
          state_next = ST_TK_LIVE;
        end else begin
          state_next = ST_TK_LAST;
        end
      end
      ST_TK_LAST: state_next = ST_SD_RDL;
      ST_SD_RDL:  state_next = l_in ? ST_SD_RDR : ST_TK_LIVE;
      ST_SD_RDR:  state_next = r_in ? ST_SD_CMPR : ST_SD_MOVE;
      ST_SD_CMPR: state_next = ST_SD_MOVE;
      ST_SD_MOVE: state_next = m_self ? ST_TK_LIVE : ST_SD_RDL;
      ST_TK_LIVE: state_next = ST_TK_RD0;
      // ST_RES: single result waiting for the output register
      ST_TK_DONE: state_next = out_free ? ST_IDLE : ST_TK_DONE;
      // tick end: idle result if nothing fired, else drain the fire buffer
      ST_EM_RD: state_next = (fire_n == '0) ? ST_TK_DONE : ST_EM_OUT;
      ST_EM_OUT: begin
        if (out_free) begin
          state_next = em_last ? ST_IDLE : ST_EM_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ram and handshake controls
  always_comb begin
    cmd.ready = state == ST_IDLE;
    hp_we     = 1'b0;
    hp_waddr  = hp_i;
    hp_wdata  = {e_t, e_s, e_g};
    hp_raddr  = '0;
    fb_we     = 1'b0;
    case (state)
      ST_PU_RD: begin
        hp_raddr = parent;
        hp_we    = hp_i == '0;
      end
      ST_PU_CMP: begin
        hp_we = 1'b1;
        if (cmp_lt) begin
          hp_wdata = hp_rdata;
        end
      end
      ST_TK_CHK: hp_raddr = AW'(heap_count - 1'b1);
      ST_SD_RDL: begin
        hp_raddr = l_w[AW-1:0];
        hp_we    = !l_in;
      end
      ST_SD_RDR: hp_raddr = r_w[AW-1:0];
      ST_SD_MOVE: begin
        hp_we = 1'b1;
        if (!m_self) begin
          hp_wdata = {best_t, best_s, best_g};
        end
      end
      ST_TK_LIVE: fb_we = live;
      default: begin
        hp_we = 1'b0;
      end
    endcase
  end

  tqs_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap_ram (
    .clk   (clk),
    .we    (hp_we),
    .waddr (hp_waddr),
    .wdata (hp_wdata),
    .raddr (hp_raddr),
    .rdata (hp_rdata)
  );

  tqs_ram #(.WIDTH(BW), .DEPTH(MAX_RESULTS)) u_fire_ram (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fire_n[FW-1:0]),
    .wdata ({pop_t, pop_s}),
    .raddr (em_ix),
    .rdata (fb_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // heap top tracking
  always_ff @(posedge clk) begin
    if (hp_we && hp_waddr == '0) begin
      top_t <= hp_wdata[EW-1 -: TIME_W];
    end
  end

  // control state and slot tables
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_count <= '0;
      fire_n     <= '0;
      for (int k = 0; k < NUM_TIMERS; k++) begin
        slot_exp[k] <= NEVER_TIME;
        slot_gen[k] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          fire_n <= '0;
          if (cmd_take && cmd.action == ACT_CANCEL && cmd_id_ok) begin
            slot_gen[cmd_ix] <= slot_gen[cmd_ix] + 1'b1;
            slot_exp[cmd_ix] <= NEVER_TIME;
          end
        end
        ST_ARM_DEC: begin
          if (!soon_block && !heap_full) begin
            slot_gen[id_ix] <= slot_gen[id_ix] + 1'b1;
            slot_exp[id_ix] <= exp_r;
            if (need_push) begin
              heap_count <= heap_count + 1'b1;
            end
          end
        end
        ST_TK_CHK: begin
          if (!cmp_lt) begin
            heap_count <= heap_count - 1'b1;
          end
        end
        ST_TK_LIVE: begin
          if (live) begin
            slot_exp[pop_s] <= NEVER_TIME;
            fire_n          <= fire_n + 1'b1;
          end
        end
        default: begin
          fire_n <= fire_n;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        r_id      <= cmd.timer_id;
        r_now     <= cmd.now_time;
        r_wait    <= cmd.wait_time;
        r_soon    <= cmd.only_if_sooner;
        res_exp    <= NEVER_TIME;
        res_early  <= 1'b0;
        em_ix      <= '0;
        case (cmd.action)
          ACT_ARM: begin
            res_kind   <= KIND_ARM;
            res_status <= STATUS_FULL;
            res_id     <= cmd.timer_id;
          end
          ACT_CANCEL: begin
            res_kind   <= KIND_CANCEL;
            res_status <= STATUS_OK;
            res_id     <= cmd.timer_id;
          end
          default: begin
            res_kind   <= KIND_IDLE;
            res_status <= STATUS_OK;
            res_id     <= '0;
          end
        endcase
      end
      ST_ARM_EXP: begin
        exp_r      <= exp_calc;
        res_status <= STATUS_OK;
      end
      ST_ARM_DEC: begin
        if (soon_block) begin
          res_exp <= slot_exp[id_ix];
        end else if (heap_full) begin
          res_status <= STATUS_FULL;
          res_exp    <= slot_exp[id_ix];
        end else begin
          res_exp <= exp_r;
          e_t     <= exp_r;
          e_s     <= id_ix;
          e_g     <= slot_gen[id_ix] + 1'b1;
          hp_i    <= heap_count[AW-1:0];
        end
      end
      ST_PU_RD: begin
        if (hp_i == '0) begin
          res_early <= 1'b1;
        end
      end
      ST_PU_CMP: begin
        if (cmp_lt) begin
          hp_i <= parent;
        end
      end
      ST_TK_CHK: begin
        pop_t <= rd_t;
        pop_s <= rd_s;
        pop_g <= rd_g;
      end
      ST_TK_LAST: begin
        e_t  <= rd_t;
        e_s  <= rd_s;
        e_g  <= rd_g;
        hp_i <= '0;
      end
      ST_SD_RDR: begin
        if (cmp_lt) begin
          best_t <= rd_t;
          best_s <= rd_s;
          best_g <= rd_g;
          m_ix   <= l_w[AW-1:0];
          m_self <= 1'b0;
        end else begin
          best_t <= e_t;
          best_s <= e_s;
          best_g <= e_g;
          m_ix   <= hp_i;
          m_self <= 1'b1;
        end
      end
      ST_SD_CMPR: begin
        if (cmp_lt) begin
          best_t <= rd_t;
          best_s <= rd_s;
          best_g <= rd_g;
          m_ix   <= r_w[AW-1:0];
          m_self <= 1'b0;
        end
      end
      ST_SD_MOVE: begin
        if (!m_self) begin
          hp_i <= m_ix;
        end
      end
      ST_EM_OUT: begin
        if (out_free && !em_last) begin
          em_ix <= em_ix + 1'b1;
        end
      end
      default: begin
        hp_i <= hp_i;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((state == ST_TK_DONE || state == ST_EM_OUT) && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      rsp.next_expiry <= (heap_count != '0) ? top_t : NEVER_TIME;
      if (state == ST_TK_DONE) begin
        rsp.kind         <= res_kind;
        rsp.status       <= res_status;
        rsp.fired_timer  <= res_id;
        rsp.expiry       <= res_exp;
        rsp.new_earliest <= res_early;
        rsp.last         <= 1'b1;
      end else if (state == ST_EM_OUT) begin
        rsp.kind         <= KIND_FIRE;
        rsp.status       <= STATUS_OK;
        rsp.fired_timer  <= ID_W'(fb_rdata[IDW-1:0]);
        rsp.expiry       <= fb_rdata[BW-1 -: TIME_W];
        rsp.new_earliest <= 1'b0;
        rsp.last         <= em_last;
      end
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    heap_count <= CNT_W'(HEAP_DEPTH))
    else $error("heap count above depth");

  a_fire_bound: assert property (@(posedge clk) disable iff (rst)
    fire_n <= NW'(MAX_RESULTS))
    else $error("fire buffer overrun");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> !cmd.ready)
    else $error("accepted a command while one is in progress");

  a_parent_nonroot: assert property (@(posedge clk) disable iff (rst)
    state == ST_PU_CMP |-> hp_i != '0)
    else $error("sift-up compare at root");

endmodule

@@ test/timer_queue_scheduler_top_tb.sv @@
// ----------------------------------------------------------------------------
// timer_queue_scheduler_top_tb
// Drives arm, cancel and tick commands into the timer queue scheduler and
// compares every result transaction with a behavioral model of the slots
// and the min-heap, under several idling and backpressure phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timer_queue_scheduler_top_tb;
  import tqs_pkg::*;

  localparam int SLOTS  = 16;
  localparam int DEPTH  = 32;
  localparam int LIMIT  = 20000;

  typedef struct packed {
    kind_t             kind;
    logic              status;
    logic [ID_W-1:0]   fired_timer;
    logic [TIME_W-1:0] expiry;
    logic              new_earliest;
    logic [TIME_W-1:0] next_expiry;
    logic              last;
  } result_t;

  int errors = 0;

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  // scheduler behavior and queue of pending results
  class timer_scoreboard;
    logic [TIME_W-1:0] exp_of[SLOTS];
    logic [15:0]       gen_of[SLOTS];
    logic [TIME_W-1:0] h_time[DEPTH];
    logic [ID_W-1:0]   h_slot[DEPTH];
    logic [15:0]       h_gen[DEPTH];
    int                count;
    result_t           pending[$];

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        exp_of[i] = NEVER_TIME;
        gen_of[i] = '0;
      end
      count = 0;
    endfunction

    function void swap(int a, int b);
      logic [TIME_W-1:0] t;
      logic [ID_W-1:0] s;
      logic [15:0] g;
      t = h_time[a]; h_time[a] = h_time[b]; h_time[b] = t;
      s = h_slot[a]; h_slot[a] = h_slot[b]; h_slot[b] = s;
      g = h_gen[a]; h_gen[a] = h_gen[b]; h_gen[b] = g;
    endfunction

    function int push(logic [TIME_W-1:0] t, logic [ID_W-1:0] s, logic [15:0] g);
      int i;
      int p;
      i = count++;
      h_time[i] = t; h_slot[i] = s; h_gen[i] = g;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!(h_time[p] > h_time[i])) break;
        swap(p, i);
        i = p;
      end
      return i;
    endfunction

    function void pop();
      int i;
      int l;
      int r;
      int m;
      i = 0;
      count--;
      if (count == 0) return;
      h_time[0] = h_time[count]; h_slot[0] = h_slot[count]; h_gen[0] = h_gen[count];
      forever begin
        l = 2 * i + 1; r = l + 1; m = i;
        if (l < count && h_time[l] < h_time[m]) m = l;
        if (r < count && h_time[r] < h_time[m]) m = r;
        if (m == i) break;
        swap(i, m);
        i = m;
      end
    endfunction

    // note an accepted command and queue the results it causes
    function void note_command(action_t act, logic [ID_W-1:0] id, logic [TIME_W-1:0] now,
                               logic [WAIT_W-1:0] wt, logic sooner);
      result_t res[$];
      result_t r;
      logic [TIME_W-1:0] e;
      logic [TIME_W-1:0] t;
      logic [ID_W-1:0] s;
      logic [15:0] g;
      r = '0;
      r.expiry = NEVER_TIME;
      case (act)
        ACT_ARM: begin
          r.kind = KIND_ARM;
          r.fired_timer = id;
          if (wt == WAIT_NEVER) e = NEVER_TIME;
          else if (now >= LAST_TIME || {16'd0, wt} > LAST_TIME - now) e = LAST_TIME;
          else e = now + wt;
          if (sooner && !(e < exp_of[id])) begin
            r.expiry = exp_of[id];
          end else if (e != NEVER_TIME && count >= DEPTH) begin
            r.status = STATUS_FULL;
            r.expiry = exp_of[id];
          end else begin
            gen_of[id]++;
            exp_of[id] = e;
            r.expiry = e;
            if (e != NEVER_TIME) r.new_earliest = (push(e, id, gen_of[id]) == 0);
          end
          res.push_back(r);
        end
        ACT_CANCEL: begin
          gen_of[id]++;
          exp_of[id] = NEVER_TIME;
          r.kind = KIND_CANCEL;
          r.fired_timer = id;
          res.push_back(r);
        end
        ACT_TICK: begin
          while (count > 0 && h_time[0] <= now && res.size() < MAX_RESULTS) begin
            t = h_time[0]; s = h_slot[0]; g = h_gen[0];
            pop();
            if (g == gen_of[s]) begin
              exp_of[s] = NEVER_TIME;
              r.kind = KIND_FIRE;
              r.fired_timer = s;
              r.expiry = t;
              res.push_back(r);
            end
          end
        end
        default: ;
      endcase
      if (res.size() == 0) begin
        r = '0;
        r.kind = KIND_IDLE;
        r.expiry = NEVER_TIME;
        res.push_back(r);
      end
      foreach (res[k]) begin
        res[k].next_expiry = count > 0 ? h_time[0] : NEVER_TIME;
        res[k].last = (k == res.size() - 1);
        pending.push_back(res[k]);
      end
    endfunction

    // compare one result transaction with the oldest pending one
    task check_result(result_t got);
      result_t w;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      w = pending.pop_front();
      if (got.kind != w.kind) report($sformatf("kind %0d, want %0d", got.kind, w.kind));
      if (got.status != w.status) report($sformatf("status %0d, want %0d", got.status, w.status));
      if (got.fired_timer != w.fired_timer)
        report($sformatf("timer %0d, want %0d", got.fired_timer, w.fired_timer));
      if (got.expiry != w.expiry) report($sformatf("expiry %h, want %h", got.expiry, w.expiry));
      if (got.new_earliest != w.new_earliest)
        report($sformatf("new_earliest %0d, want %0d", got.new_earliest, w.new_earliest));
      if (got.next_expiry != w.next_expiry)
        report($sformatf("next_expiry %h, want %h", got.next_expiry, w.next_expiry));
      if (got.last != w.last) report($sformatf("last %0d, want %0d", got.last, w.last));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  tqs_cmd_if cmd();
  tqs_rsp_if rsp();

  timer_queue_scheduler_top u_dut (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp));

  timer_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int hold_off = 0;
  int quiet = 0;
  logic [TIME_W-1:0] clock_now = 48'd1000;

  initial begin
    forever #4 clk = ~clk;
  end

  // result side: random stall, long hold-off, checking
  initial begin
    rsp.ready = 0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready)
        sb.check_result({kind_t'(rsp.kind), rsp.status, rsp.fired_timer, rsp.expiry,
                         rsp.new_earliest, rsp.next_expiry, rsp.last});
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        rsp.ready <= 0;
      end else begin
        rsp.ready <= !rst && ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    forever begin
      @(posedge clk);
      if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || rst || hold_off > 0)
        quiet = 0;
      else quiet++;
      if (quiet >= LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // valid stays high after a transaction so commands can follow back to back
  task automatic send(action_t act, logic [ID_W-1:0] id, logic [TIME_W-1:0] now,
                      logic [WAIT_W-1:0] wt, logic sooner);
    while ($urandom_range(99) < send_idle) begin
      cmd.valid <= 0;
      @(posedge clk);
    end
    cmd.valid <= 1;
    cmd.action <= act;
    cmd.timer_id <= id;
    cmd.now_time <= now;
    cmd.wait_time <= wt;
    cmd.only_if_sooner <= sooner;
    do @(posedge clk); while (!cmd.ready);
    sb.note_command(act, id, now, wt, sooner);
  endtask

  task automatic drain();
    cmd.valid <= 0;
    while (sb.pending.size() > 0) @(posedge clk);
  endtask

  // mostly short waits around a moving clock so timers fire often
  task automatic random_item();
    int sel;
    logic [WAIT_W-1:0] wt;
    logic [TIME_W-1:0] now;
    sel = $urandom_range(99);
    clock_now = clock_now + $urandom_range(40);
    now = clock_now;
    if ($urandom_range(19) == 0) now = {$urandom, $urandom};
    case ($urandom_range(9))
      0: wt = $urandom;
      1: wt = WAIT_NEVER;
      default: wt = $urandom_range(200);
    endcase
    if (sel < 50) send(ACT_ARM, $urandom, now, wt, $urandom);
    else if (sel < 65) send(ACT_CANCEL, $urandom, now, wt, $urandom);
    else if (sel < 97) send(ACT_TICK, $urandom, now, wt, $urandom);
    else send(ACT_NONE, $urandom, now, wt, $urandom);
  endtask

  initial begin
    cmd.valid = 0;
    cmd.action = ACT_NONE;
    cmd.timer_id = '0;
    cmd.now_time = '0;
    cmd.wait_time = '0;
    cmd.only_if_sooner = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty tick, extremes, sooner rule, saturation, full heap
    send(ACT_TICK, 0, NEVER_TIME, 0, 0);
    send(ACT_NONE, 4'hf, 0, 0, 1);
    send(ACT_ARM, 0, 0, 0, 0);
    send(ACT_ARM, 15, NEVER_TIME, 32'hffff_fffe, 0);
    send(ACT_ARM, 1, 48'hffff_ffff_0000, 32'hffff_fffe, 0);
    send(ACT_ARM, 2, 100, WAIT_NEVER, 0);
    send(ACT_ARM, 3, 100, 50, 0);
    send(ACT_ARM, 3, 100, 60, 1);
    send(ACT_ARM, 3, 100, 10, 1);
    send(ACT_ARM, 4, 100, 10, 0);
    send(ACT_CANCEL, 4, 0, 0, 0);
    send(ACT_TICK, 0, 200, 0, 0);
    send(ACT_ARM, 5, 0, 0, 0);
    send(ACT_ARM, 5, 0, 0, 0);
    for (int i = 0; i < 34; i++) send(ACT_ARM, i[3:0], TIME_W'(i), 5, 0);
    send(ACT_ARM, 6, 0, WAIT_NEVER, 1);
    send(ACT_TICK, 0, 1000, 0, 0);
    send(ACT_TICK, 0, NEVER_TIME, 0, 0);
    drain();

    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 3 ? 26 : 73) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 3 ? 26 : 73) : 0;
      if (ph == 0) hold_off <= 300;
      for (int n = 0; n < 55; n++) random_item();
      drain();
    end
    recv_stall = 0;
    repeat (50) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
